@@ sv/ship_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ship_pkg
// shared types and constants of the stream-aware rrip replacement engine
// ----------------------------------------------------------------------------
package ship_pkg;

   localparam int NUM_SETS_DEF          = 2048;
   localparam int NUM_WAYS_DEF          = 16;
   localparam int REUSE_TABLE_DEPTH_DEF = 8192;
   localparam int LEADER_SETS_DEF       = 32;
   localparam int SELECTOR_BITS_DEF     = 10;

   localparam logic [1:0]  AGE_MAX     = 2'd3;
   localparam logic [1:0]  AGE_LONG    = 2'd2;
   localparam logic [1:0]  AGE_NEAR    = 2'd0;
   localparam logic [1:0]  REUSE_INIT  = 2'd1;
   localparam logic [1:0]  REUSE_MAX   = 2'd3;
   localparam logic [1:0]  REUSE_HOT   = 2'd2;
   localparam logic [15:0] LFSR_SEED   = 16'd44257;
   localparam logic [15:0] LFSR_TAPS   = 16'hB400;
   localparam logic [4:0]  LFSR_ZERO   = 5'd0;
   localparam int          BLOCK_SHIFT = 6;
   localparam logic [3:0]  SCORE_MAX   = 4'd15;
   localparam logic [3:0]  SCORE_MIN   = 4'd0;
   localparam logic [3:0]  STREAM_ON   = 4'd8;
   localparam logic        MODE_VICTIM = 1'b0;
   localparam logic [1:0]  ACCESS_LOAD = 2'd0;

   typedef struct packed {
      logic        mode;
      logic [10:0] set_index;
      logic [3:0]  way;
      logic [63:0] address;
      logic [63:0] program_counter;
      logic [1:0]  access_type;
      logic        hit;
   } req_type;

   typedef struct packed {
      logic [3:0] victim_way;
      logic       streaming;
      logic [1:0] inserted_age;
   } rsp_type;

   typedef struct packed {
      logic [63:0] last_address;
      logic [31:0] deltas;
      logic [1:0]  slot;
      logic [3:0]  score;
   } stream_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CALC
   } state_type;

endpackage

@@ sv/ship_drrip_stream_replacement.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ship_drrip_stream_replacement
// rrip replacement engine with pc reuse table, stream detector, set dueling
// ----------------------------------------------------------------------------
// channel  ports                    direction  transfer
// request  start, busy, req_item    in         start high while busy low
// result   rsp_valid, rsp_item      out        rsp_valid high for one cycle
//
// for each request the set, reuse and stream memories are read at the
// transfer edge; in the next cycle the age row, an update's stream entry
// and an update hit's reuse counter are modified and written back. after reset a
// clearing pass over max(NUM_SETS, REUSE_TABLE_DEPTH) entries runs with
// busy high. the result strobe follows the calc cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module ship_drrip_stream_replacement
   #(parameter int NUM_SETS          = ship_pkg::NUM_SETS_DEF,
     parameter int NUM_WAYS          = ship_pkg::NUM_WAYS_DEF,
     parameter int REUSE_TABLE_DEPTH = ship_pkg::REUSE_TABLE_DEPTH_DEF,
     parameter int LEADER_SETS       = ship_pkg::LEADER_SETS_DEF,
     parameter int SELECTOR_BITS     = ship_pkg::SELECTOR_BITS_DEF)
   (input  logic              clock,
    input  logic              reset,
    input  logic              start,
    output logic              busy,
    input  ship_pkg::req_type req_item,
    output logic              rsp_valid,
    output ship_pkg::rsp_type rsp_item);

   import ship_pkg::*;

   localparam int SET_W     = $clog2(NUM_SETS);
   localparam int WAY_W     = $clog2(NUM_WAYS);
   localparam int SIG_W     = $clog2(REUSE_TABLE_DEPTH);
   localparam int CLR_DEPTH = (NUM_SETS > REUSE_TABLE_DEPTH) ? NUM_SETS : REUSE_TABLE_DEPTH;
   localparam int CLR_W     = $clog2(CLR_DEPTH);
   localparam int ROW_W     = 2 * NUM_WAYS;
   localparam logic [SELECTOR_BITS-1:0] SEL_MAX = {SELECTOR_BITS{1'b1}};
   localparam logic [SELECTOR_BITS-1:0] SEL_MID = SEL_MAX >> 1;
   localparam logic [SET_W:0] LEAD_S_LIM = (SET_W+1)'(LEADER_SETS);
   localparam logic [SET_W:0] LEAD_B_LIM = (SET_W+1)'(NUM_SETS - LEADER_SETS);

   logic [ROW_W-1:0] age_mem    [NUM_SETS];
   stream_type       stream_mem [NUM_SETS];
   logic [1:0]       reuse_mem  [REUSE_TABLE_DEPTH];

   state_type              state_ff, state_in;
   logic [CLR_W-1:0]       clr_ff, clr_in;
   req_type                req_ff;
   logic [ROW_W-1:0]       age_rd_ff;
   stream_type             stream_rd_ff;
   logic [1:0]             reuse_rd_ff;
   logic [SELECTOR_BITS-1:0] sel_ff, sel_in;
   logic [15:0]            lfsr_ff, lfsr_in;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff, rsp_in;

   logic             accept, clr_last, calc, clearing;
   logic [SET_W-1:0] set_rd, set_cur;
   logic [SIG_W-1:0] sig_rd, sig_cur;
   logic [63:0]      pc_mix;
   logic [WAY_W-1:0] way_cur;

   logic [1:0]       age_max, age_add, new_age;
   logic [WAY_W-1:0] victim;
   logic [ROW_W-1:0] age_wr;
   logic [63:0]      delta;
   logic [7:0]       d;
   logic [31:0]      h;
   logic             eq, strm, lead_s, lead_b, srrip, draw;
   stream_type       stream_wr;
   logic [1:0]       reuse_wr;

   assign accept = start && !busy;

   assign pc_mix = req_item.program_counter ^ (req_item.program_counter >> 16);
   assign sig_rd = pc_mix[SIG_W-1:0];
   assign set_rd = SET_W'(req_item.set_index);
   assign set_cur = SET_W'(req_ff.set_index);
   assign sig_cur = SIG_W'(req_ff.program_counter ^ (req_ff.program_counter >> 16));
   assign way_cur = WAY_W'(req_ff.way);
   assign clr_last = (clr_ff == CLR_W'(CLR_DEPTH - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_last) state_in = ST_IDLE;
         ST_IDLE:  if (start) state_in = ST_CALC;
         ST_CALC:  state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      busy     = 1'b1;
      calc     = 1'b0;
      clearing = 1'b0;
      case (state_ff)
         ST_CLEAR: clearing = 1'b1;
         ST_IDLE:  busy = 1'b0;
         ST_CALC:  calc = 1'b1;
         default:  busy = 1'b1;
      endcase
   end

   assign clr_in = clearing ? clr_ff + 1'b1 : clr_ff;

   // victim path
   always_comb begin
      age_max = 2'd0;
      for (int i = 0; i < NUM_WAYS; i++) begin
         if (age_rd_ff[2*i +: 2] > age_max) age_max = age_rd_ff[2*i +: 2];
      end
      age_add = AGE_MAX - age_max;
      victim  = '0;
      for (int i = NUM_WAYS - 1; i >= 0; i--) begin
         if (age_rd_ff[2*i +: 2] == age_max) victim = WAY_W'(i);
      end
   end

   // stream detector and insertion
   always_comb begin
      delta = req_ff.address - stream_rd_ff.last_address;
      d     = delta[BLOCK_SHIFT +: 8];
      for (int b = 0; b < 4; b++) begin
         h[8*b +: 8] = (stream_rd_ff.slot == 2'(b)) ? d : stream_rd_ff.deltas[8*b +: 8];
      end
      eq = (h[7:0] != 8'd0) && (h[15:8] == h[7:0]) && (h[23:16] == h[7:0])
           && (h[31:24] == h[7:0]);
      stream_wr.last_address = req_ff.address;
      stream_wr.deltas       = h;
      stream_wr.slot         = stream_rd_ff.slot + 2'd1;
      stream_wr.score        = stream_rd_ff.score;
      if (eq) begin
         if (stream_rd_ff.score < SCORE_MAX) stream_wr.score = stream_rd_ff.score + 4'd1;
      end else begin
         if (stream_rd_ff.score > SCORE_MIN) stream_wr.score = stream_rd_ff.score - 4'd1;
      end
      strm = (stream_wr.score >= STREAM_ON);

      lead_s = ({1'b0, set_cur} < LEAD_S_LIM);
      lead_b = ({1'b0, set_cur} >= LEAD_B_LIM);
      srrip  = lead_s || (!lead_b && (sel_ff >= SEL_MID));

      lfsr_in  = lfsr_ff;
      draw     = 1'b0;
      reuse_wr = reuse_rd_ff;
      if (req_ff.hit) begin
         new_age = AGE_NEAR;
         if (reuse_rd_ff < REUSE_MAX) reuse_wr = reuse_rd_ff + 2'd1;
      end else begin
         if (reuse_rd_ff >= REUSE_HOT)      new_age = AGE_NEAR;
         else if (reuse_rd_ff == REUSE_INIT) new_age = AGE_LONG;
         else                                new_age = AGE_MAX;
         if (strm) new_age = AGE_MAX;
         if (srrip) begin
            if (new_age > AGE_LONG) new_age = AGE_LONG;
         end else if (lead_b) begin
            draw    = 1'b1;
            lfsr_in = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? LFSR_TAPS : 16'd0);
            if (lfsr_in[4:0] == LFSR_ZERO)  new_age = AGE_MAX;
            else if (new_age > AGE_LONG)    new_age = AGE_LONG;
         end
      end

      sel_in = sel_ff;
      if (req_ff.hit && (req_ff.access_type == ACCESS_LOAD)) begin
         if (lead_s && (sel_ff < SEL_MAX)) sel_in = sel_ff + 1'b1;
         if (lead_b && (sel_in > '0)) sel_in = sel_in - 1'b1;
      end

      if (req_ff.mode == MODE_VICTIM) begin
         for (int i = 0; i < NUM_WAYS; i++) begin
            age_wr[2*i +: 2] = age_rd_ff[2*i +: 2] + age_add;
         end
         rsp_in.victim_way   = 4'(victim);
         rsp_in.streaming    = (stream_rd_ff.score >= STREAM_ON);
         rsp_in.inserted_age = AGE_NEAR;
      end else begin
         age_wr = age_rd_ff;
         age_wr[2*way_cur +: 2] = new_age;
         rsp_in.victim_way   = 4'd0;
         rsp_in.streaming    = strm;
         rsp_in.inserted_age = new_age;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (clearing && ({1'b0, clr_ff} < (CLR_W+1)'(NUM_SETS))) begin
         age_mem[SET_W'(clr_ff)]    <= {NUM_WAYS{AGE_MAX}};
         stream_mem[SET_W'(clr_ff)] <= '0;
      end else if (calc) begin
         age_mem[set_cur] <= age_wr;
         if (req_ff.mode != MODE_VICTIM) stream_mem[set_cur] <= stream_wr;
      end
      if (accept) begin
         age_rd_ff    <= age_mem[set_rd];
         stream_rd_ff <= stream_mem[set_rd];
      end
   end

   always_ff @(posedge clock) begin
      if (clearing && ({1'b0, clr_ff} < (CLR_W+1)'(REUSE_TABLE_DEPTH))) begin
         reuse_mem[SIG_W'(clr_ff)] <= REUSE_INIT;
      end else if (calc && (req_ff.mode != MODE_VICTIM) && req_ff.hit) begin
         reuse_mem[sig_cur] <= reuse_wr;
      end
      if (accept) begin
         reuse_rd_ff <= reuse_mem[sig_rd];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         sel_ff       <= SEL_MID;
         lfsr_ff      <= LFSR_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= calc;
         if (calc && (req_ff.mode != MODE_VICTIM)) begin
            sel_ff <= sel_in;
            if (draw) lfsr_ff <= lfsr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_item;
      if (calc) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

@@ verif/ship_drrip_stream_replacement_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ship_drrip_stream_replacement_tb
// self-checking bench: directed and random victim and update requests are
// driven through the start/busy handshake, each transfer is predicted by a
// scoreboard that mirrors ages, reuse counters, stream detector, duel
// selector and lfsr, and every result strobe is compared field by field
// ----------------------------------------------------------------------------
module ship_drrip_stream_replacement_tb;
   import ship_pkg::*;

   localparam int NSETS    = NUM_SETS_DEF;
   localparam int NWAYS    = NUM_WAYS_DEF;
   localparam int NREUSE   = REUSE_TABLE_DEPTH_DEF;
   localparam int NLEAD    = LEADER_SETS_DEF;
   localparam logic [9:0] SEL_TOP = 10'h3FF;
   localparam logic [9:0] SEL_MID = 10'd511;
   localparam logic       MODE_UPDATE = 1'b1;
   localparam int CYCLE_LIMIT = 400000;

   class replacement_scoreboard;
      logic [1:0]  age_mem [NSETS*NWAYS];
      logic [1:0]  reuse_mem [NREUSE];
      stream_type  stream_mem [NSETS];
      logic [9:0]  selector;
      logic [15:0] lfsr;
      rsp_type     pending [$];
      int          errors;
      int          checked;

      function new();
         foreach (age_mem[i]) age_mem[i] = AGE_MAX;
         foreach (reuse_mem[i]) reuse_mem[i] = REUSE_INIT;
         foreach (stream_mem[i]) stream_mem[i] = '0;
         selector = SEL_MID;
         lfsr = LFSR_SEED;
         errors = 0;
         checked = 0;
      endfunction

      function void note_transfer(req_type r);
         rsp_type     e;
         int          base, sig;
         logic [1:0]  mx, ag, c;
         logic [63:0] dl;
         logic [7:0]  d, r0;
         logic [31:0] h;
         logic        strm, ls, lb, srr, brr;
         base = int'(r.set_index) * NWAYS;
         e = '0;
         if (r.mode == MODE_VICTIM) begin
            mx = 2'd0;
            for (int i = 0; i < NWAYS; i++) if (age_mem[base+i] > mx) mx = age_mem[base+i];
            for (int i = 0; i < NWAYS; i++) age_mem[base+i] = age_mem[base+i] + (AGE_MAX - mx);
            for (int i = NWAYS - 1; i >= 0; i--)
               if (age_mem[base+i] == AGE_MAX) e.victim_way = 4'(i);
            e.streaming = stream_mem[r.set_index].score >= STREAM_ON;
         end else begin
            sig = int'((r.program_counter ^ (r.program_counter >> 16)) % NREUSE);
            dl = r.address - stream_mem[r.set_index].last_address;
            d = dl[13:6];
            h = stream_mem[r.set_index].deltas;
            h[8*stream_mem[r.set_index].slot +: 8] = d;
            stream_mem[r.set_index].deltas = h;
            stream_mem[r.set_index].slot++;
            stream_mem[r.set_index].last_address = r.address;
            r0 = h[7:0];
            if (r0 != 0 && h[15:8] == r0 && h[23:16] == r0 && h[31:24] == r0) begin
               if (stream_mem[r.set_index].score < SCORE_MAX) stream_mem[r.set_index].score++;
            end else if (stream_mem[r.set_index].score > SCORE_MIN) begin
               stream_mem[r.set_index].score--;
            end
            strm = stream_mem[r.set_index].score >= STREAM_ON;
            ls = r.set_index < NLEAD;
            lb = r.set_index >= NSETS - NLEAD;
            if (r.hit) begin
               if (reuse_mem[sig] < REUSE_MAX) reuse_mem[sig]++;
               ag = AGE_NEAR;
            end else begin
               srr = ls;
               brr = lb;
               if (!srr && !brr) srr = selector >= SEL_MID;
               c = reuse_mem[sig];
               ag = (c >= REUSE_HOT) ? AGE_NEAR : (c == REUSE_INIT ? AGE_LONG : AGE_MAX);
               if (strm) ag = AGE_MAX;
               if (srr) begin
                  if (ag > AGE_LONG) ag = AGE_LONG;
               end else if (brr) begin
                  lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
                  if (lfsr[4:0] == LFSR_ZERO) ag = AGE_MAX;
                  else if (ag > AGE_LONG) ag = AGE_LONG;
               end
            end
            age_mem[base + r.way] = ag;
            if (r.hit && r.access_type == ACCESS_LOAD) begin
               if (ls && selector < SEL_TOP) selector++;
               if (lb && selector > 0) selector--;
            end
            e.streaming = strm;
            e.inserted_age = ag;
         end
         pending.push_back(e);
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("result with no request outstanding: %h", a);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (a.victim_way !== e.victim_way) begin
            $error("victim_way expected %0d actual %0d", e.victim_way, a.victim_way);
            errors++;
         end
         if (a.streaming !== e.streaming) begin
            $error("streaming expected %0d actual %0d", e.streaming, a.streaming);
            errors++;
         end
         if (a.inserted_age !== e.inserted_age) begin
            $error("inserted_age expected %0d actual %0d", e.inserted_age, a.inserted_age);
            errors++;
         end
      endfunction
   endclass

   logic    clock, reset, start, busy, rsp_valid;
   req_type req_item;
   rsp_type rsp_item;
   int      cycles = 0;
   int      n_victim, n_update;
   bit      calm;
   replacement_scoreboard sb;

   ship_drrip_stream_replacement uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item));

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && start && !busy) sb.note_transfer(req_item);
      if (!reset && rsp_valid) sb.check_result(rsp_item);
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("ship_drrip_stream_replacement: mismatch");
         $finish;
      end
   end

   // drive one request and hold it until the transfer edge
   task automatic send(req_type r);
      if (!calm)
         while ($urandom_range(99) < 27) begin
            start <= 1'b0;
            @(negedge clock);
         end
      req_item <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      if (r.mode == MODE_VICTIM) n_victim++; else n_update++;
      @(negedge clock);
   endtask

   function automatic req_type make(logic m, int s, int w, logic [63:0] a,
                                    logic [63:0] pc, logic [1:0] t, logic h);
      req_type r;
      r.mode = m; r.set_index = 11'(s); r.way = 4'(w); r.address = a;
      r.program_counter = pc; r.access_type = t; r.hit = h;
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int pick_set();
      case ($urandom_range(3))
         0: return $urandom_range(NLEAD - 1);
         1: return NSETS - 1 - $urandom_range(NLEAD - 1);
         2: return $urandom_range(40, 47);
         default: return $urandom_range(NSETS - 1);
      endcase
   endfunction

   initial begin
      req_type     r;
      logic [63:0] a, pc;
      int          s, stride;
      sb = new();
      n_victim = 0; n_update = 0; calm = 0;
      start = 0; req_item = '0; reset = 1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: extremes, hits and misses, leaders, a clean stride stream
      send(make(MODE_VICTIM, 0, 0, '0, '0, ACCESS_LOAD, 0));
      send(make(MODE_UPDATE, 0, 0, '0, '0, ACCESS_LOAD, 1));
      send(make(MODE_UPDATE, 2047, 15, '1, '1, 2'd3, 0));
      send(make(MODE_UPDATE, 2047, 15, '1, '1, ACCESS_LOAD, 1));
      send(make(MODE_VICTIM, 2047, 15, '1, '1, 2'd3, 1));
      send(make(MODE_UPDATE, 100, 3, 64'h1234, 64'h5555_0000, 2'd1, 0));
      send(make(MODE_UPDATE, 100, 3, 64'h1234, 64'h5555_0000, 2'd2, 1));
      send(make(MODE_UPDATE, 100, 4, 64'h1234, 64'h5555_0000, ACCESS_LOAD, 0));
      for (int i = 1; i <= 13; i++)
         send(make(MODE_UPDATE, 5, i, 64'(i * 128), 64'h40, ACCESS_LOAD, 0));
      send(make(MODE_VICTIM, 5, 0, '0, '0, ACCESS_LOAD, 0));
      send(make(MODE_VICTIM, 0, 0, '0, '0, ACCESS_LOAD, 0));

      // random: stride streams into hot sets mixed with noise
      for (int k = 0; k < 950; k++) begin
         calm = (k >= 300 && k < 420);
         if ($urandom_range(3) == 0) begin
            s = pick_set();
            stride = $urandom_range(1, 5) * 64;
            a = rand64();
            pc = 64'($urandom_range(63)) << 2;
            for (int j = 0; j < 10; j++) begin
               send(make(MODE_UPDATE, s, $urandom_range(15), a, pc,
                         2'($urandom_range(3)), $urandom_range(2) == 0));
               a = a + 64'(stride);
            end
            send(make(MODE_VICTIM, s, 0, rand64(), rand64(), 2'($urandom_range(3)), 0));
            k += 10;
         end else begin
            pc = $urandom_range(1) ? rand64() : 64'($urandom_range(31)) << 3;
            send(make($urandom_range(1), pick_set(), $urandom_range(15), rand64(), pc,
                      2'($urandom_range(3)), $urandom_range(1)));
         end
      end
      start <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("covered %0d victim and %0d update transfers, %0d results checked",
               n_victim, n_update, sb.checked);
      if (sb.errors == 0)
         $display("ship_drrip_stream_replacement: match");
      else
         $display("ship_drrip_stream_replacement: mismatch");
      $finish;
   end
endmodule

@@ sim.f @@
sv/ship_pkg.sv
sv/ship_drrip_stream_replacement.sv
verif/ship_drrip_stream_replacement_tb.sv
